/* rtl/core/spdc_pkg.sv */
package spdc_pkg;

  localparam int DATA_W    = 32;
  localparam int NEG_W     = 33;  // exact negation of a 32-bit input
  localparam int DIFF_W    = 34;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int DLY_REG_W = 5;
  localparam int FRAC_W    = 16;

  localparam int MULA_W    = 33;
  localparam int PROD_W    = 65;
  localparam int NUM_W     = 50;
  localparam int MAG_W     = 49;
  localparam int DEN_W     = 33;
  localparam int REM_W     = 34;
  localparam int DIV_STEPS = 31;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY  = 2'd0,
    REG_GAIN   = 2'd1,
    REG_PERIOD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [NEG_W-1:0]  neg_e;
    logic signed [DATA_W-1:0] neg_sat;
    logic [IDX_W-1:0]         comp;
    logic [IDX_W-1:0]         idx;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic                     start;
    logic signed [NUM_W-1:0]  num;
    logic [DEN_W-1:0]         den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quo;
  } div_rsp_t;

endpackage

/* rtl/core/spdc_front.sv */
module spdc_front
  import spdc_pkg::*;
#(
  parameter int MAX_COMPONENTS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] error_value,
  input  logic [IDX_W-1:0]         component_index,
  input  logic                     last_component,
  input  logic                     hold,
  output logic                     q_valid,
  output item_t                    q_item,
  input  logic                     q_pop
);

  localparam int QDEPTH = 2;

  item_t      slot [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       push;

  // component index folded into range by repeated subtraction
  function automatic logic [IDX_W-1:0] fold_comp(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] v;
    v = idx;
    for (int i = 0; i < (1 << IDX_W); i++) begin
      if (int'(v) >= MAX_COMPONENTS) v = IDX_W'(int'(v) - MAX_COMPONENTS);
    end
    return v;
  endfunction

  always_comb begin
    cls.neg_e   = -NEG_W'(error_value);
    cls.neg_sat = (error_value == SAT_MIN) ? SAT_MAX : -error_value;
    cls.comp    = fold_comp(component_index);
    cls.idx     = component_index;
    cls.last    = last_component;
  end

  assign in_ready = (count != 2'(QDEPTH)) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* rtl/core/spdc_div.sv */
module spdc_div
  import spdc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int PRE_W  = DATA_W - 1 - FRAC_W;
  localparam int SH_W   = PRE_W + FRAC_W;
  localparam int STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {D_IDLE, D_ABS, D_CHECK, D_RUN, D_FIN} dstate_t;

  dstate_t                 st;
  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]        den;
  logic                    neg;
  logic                    sat;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        lim;
  logic [REM_W-1:0]        rem;
  logic [REM_W-1:0]        rem_sh;
  logic [REM_W-1:0]        rem_sub;
  logic                    fits;
  logic [SH_W-1:0]         sh;
  logic [DIV_STEPS-1:0]    q;
  logic [STEP_W-1:0]       cnt;

  // quotient of mag*2^16/den stays below 2^31 iff mag < den*2^15
  assign lim     = MAG_W'(den) << PRE_W;
  assign rem_sh  = {rem[REM_W-2:0], sh[SH_W-1]};
  assign fits    = (rem_sh >= REM_W'(den));
  assign rem_sub = rem_sh - REM_W'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= D_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (st == D_FIN);
      case (st)
        D_IDLE: begin
          if (req.start) begin
            num <= req.num;
            den <= req.den;
            st  <= D_ABS;
          end
        end
        D_ABS: begin
          neg <= num[NUM_W-1];
          mag <= MAG_W'(num[NUM_W-1] ? -num : num);
          st  <= D_CHECK;
        end
        D_CHECK: begin
          if (mag >= lim) begin
            sat <= 1'b1;
            st  <= D_FIN;
          end else begin
            sat <= 1'b0;
            rem <= REM_W'(mag >> PRE_W);
            sh  <= {mag[PRE_W-1:0], FRAC_W'(0)};
            cnt <= '0;
            st  <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= fits ? rem_sub : rem_sh;
          q   <= {q[DIV_STEPS-2:0], fits};
          sh  <= sh << 1;
          cnt <= cnt + 1'b1;
          if (cnt == STEP_W'(DIV_STEPS - 1)) begin
            st <= D_FIN;
          end
        end
        D_FIN: begin
          if (sat) begin
            rsp.quo <= neg ? SAT_MIN : SAT_MAX;
          end else begin
            rsp.quo <= neg ? -DATA_W'(q) : DATA_W'(q);
          end
          st <= D_IDLE;
        end
        default: st <= D_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/spdc_back.sv */
module spdc_back
  import spdc_pkg::*;
#(
  parameter int MAX_DELAY      = 16,
  parameter int MAX_COMPONENTS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [DLY_REG_W-1:0]     delay_steps,
  input  logic [DATA_W-1:0]        loop_gain,
  input  logic [DATA_W-1:0]        sample_period,
  input  logic                     clear_req,
  output logic                     hold,
  input  logic                     q_valid,
  input  item_t                    q_item,
  output logic                     q_pop,
  output div_req_t                 div_req,
  input  div_rsp_t                 div_rsp,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] reference_value,
  output logic [IDX_W-1:0]         out_component_index,
  output logic                     out_last_component
);

  localparam int DEPTH = MAX_DELAY * MAX_COMPONENTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_GT, S_T1, S_T3, S_SUM, S_DIV, S_WB
  } state_t;

  state_t                   state;
  logic [AW-1:0]            clr_addr;
  logic [AW-1:0]            cur_addr;
  logic [AW-1:0]            rd_cur;
  logic [AW-1:0]            rd_prev;
  logic [AW-1:0]            mem_waddr;
  logic [PW-1:0]            ring;
  logic [PW-1:0]            last_pos;
  logic [PW-1:0]            prev_pos;
  logic [PW-1:0]            next_pos;

  logic signed [DATA_W-1:0] neg_mem [DEPTH];
  logic signed [DATA_W-1:0] out_mem [DEPTH];
  logic signed [DATA_W-1:0] nprev;
  logic signed [DATA_W-1:0] oprev;
  logic signed [DATA_W-1:0] od;
  logic                     mem_we;
  logic signed [DATA_W-1:0] mem_wneg;
  logic signed [DATA_W-1:0] mem_wout;
  logic                     rd_en;
  logic                     wb_go;

  item_t                    it;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        mul;
  logic [MULA_W-1:0]        mul_a;
  logic [DATA_W-1:0]        mul_b;
  logic signed [DIFF_W-1:0] diff;
  logic [MULA_W-1:0]        dmag_c;
  logic [MULA_W-1:0]        dmag;
  logic                     dneg;
  logic [DATA_W-1:0]        odmag;
  logic [DATA_W-1:0]        gt_sat;
  logic [DATA_W-1:0]        gt;
  logic signed [NUM_W-1:0]  acc;

  function automatic logic [AW-1:0] slot_addr(input logic [PW-1:0] p,
                                               input logic [IDX_W-1:0] c);
    return AW'(int'(p) * MAX_COMPONENTS + int'(c));
  endfunction

  // floor(+-m / 2^16)
  function automatic logic signed [NUM_W-1:0] floor_q16(input logic neg,
                                                        input logic [PROD_W-1:0] m);
    logic [NUM_W-1:0] q;
    q = NUM_W'(m >> FRAC_W) + NUM_W'(neg && (m[FRAC_W-1:0] != '0));
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // effective delay minus one: 0 acts as 1, large values clamp
  always_comb begin
    if (delay_steps == '0) begin
      last_pos = '0;
    end else if (int'(delay_steps) > MAX_DELAY) begin
      last_pos = PW'(MAX_DELAY - 1);
    end else begin
      last_pos = PW'(int'(delay_steps) - 1);
    end
  end

  assign prev_pos = (ring == '0) ? last_pos : ring - 1'b1;
  assign next_pos = (ring == last_pos) ? '0 : ring + 1'b1;
  assign rd_cur   = slot_addr(ring, q_item.comp);
  assign rd_prev  = slot_addr(prev_pos, q_item.comp);

  assign hold  = (state == S_CLEAR);
  assign rd_en = (state == S_IDLE) && q_valid && !clear_req;
  assign q_pop = rd_en;
  assign wb_go = (state == S_WB) && (!out_valid || out_ready);

  assign mem_we    = (state == S_CLEAR) || wb_go;
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : cur_addr;
  assign mem_wneg  = (state == S_CLEAR) ? '0 : it.neg_sat;
  assign mem_wout  = (state == S_CLEAR) ? '0 : div_rsp.quo;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      neg_mem[mem_waddr] <= mem_wneg;
      out_mem[mem_waddr] <= mem_wout;
    end
    if (rd_en) begin
      nprev <= neg_mem[rd_prev];
      oprev <= out_mem[rd_prev];
      od    <= out_mem[rd_cur];
    end
  end

  always_comb begin
    diff   = DIFF_W'(it.neg_e) - DIFF_W'(nprev);
    dmag_c = diff[DIFF_W-1] ? MULA_W'(-diff) : MULA_W'(diff);
    odmag  = od[DATA_W-1] ? DATA_W'(-od) : DATA_W'(od);
    gt_sat = (|prod[PROD_W-1:DATA_W+FRAC_W]) ? '1 : prod[DATA_W+FRAC_W-1:FRAC_W];
  end

  // one shared multiplier: g*T, then |diff|*g, then |od|*gT
  always_comb begin
    case (state)
      S_GT: begin
        mul_a = MULA_W'(loop_gain);
        mul_b = sample_period;
      end
      S_T1: begin
        mul_a = dmag;
        mul_b = loop_gain;
      end
      default: begin
        mul_a = MULA_W'(odmag);
        mul_b = gt;
      end
    endcase
    mul = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    div_req.start = (state == S_SUM);
    div_req.num   = acc + floor_q16(od[DATA_W-1], prod);
    div_req.den   = DEN_W'(gt) + (DEN_W'(1) << FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      ring      <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result loaded in the same cycle keeps out_valid high
      if (out_valid && out_ready && !(wb_go && !clear_req)) begin
        out_valid <= 1'b0;
      end
      if (clear_req) begin
        state    <= S_CLEAR;
        clr_addr <= '0;
        ring     <= '0;
      end else begin
        case (state)
          S_CLEAR: begin
            if (clr_addr == LAST_ADDR) begin
              state <= S_IDLE;
            end else begin
              clr_addr <= clr_addr + 1'b1;
            end
          end
          S_IDLE: begin
            if (rd_en) begin
              it       <= q_item;
              cur_addr <= rd_cur;
              state    <= S_GT;
            end
          end
          S_GT: begin
            prod  <= mul;
            dneg  <= diff[DIFF_W-1];
            dmag  <= dmag_c;
            state <= S_T1;
          end
          S_T1: begin
            prod  <= mul;
            gt    <= gt_sat;
            state <= S_T3;
          end
          S_T3: begin
            prod  <= mul;
            acc   <= floor_q16(dneg, prod) + NUM_W'(oprev);
            state <= S_SUM;
          end
          S_SUM: state <= S_DIV;
          S_DIV: begin
            if (div_rsp.done) begin
              state <= S_WB;
            end
          end
          S_WB: begin
            if (wb_go) begin
              out_valid           <= 1'b1;
              reference_value     <= div_rsp.quo;
              out_component_index <= it.idx;
              out_last_component  <= it.last;
              if (it.last) begin
                ring <= next_pos;
              end
              state <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

/* rtl/core/smith_predictor_delay_compensator_unit.sv */
// Smith predictor delay compensator, one error component per request.
// Input channel (in_valid/in_ready): error_value, component_index and
// last_component; the flag closes a control step and advances both history
// rings. Output channel (out_valid/out_ready): one reference_value per
// request, in order, with the index and flag echoed.
// Configuration: cfg_write with cfg_index 0 (delay_steps), 1 (loop_gain),
// 2 (sample_period), cfg_data as value; write only while no request is open.
// From acceptance to out_valid, a request passes the history memory read,
// three passes through the shared 33x32 multiplier and the 31-step
// restoring divider for the division by 1 + g*T, which a saturating result
// skips; the back end takes a new request only once the previous result
// is written to the output register.
// Reset, and every write of delay_steps, runs a clearing pass over the
// MAX_DELAY * MAX_COMPONENTS entries (128 by default) of the history memories;
// in_ready stays low during it.
// When the receiver stalls, the result waits in the output register while
// up to two further requests queue at the front and one more is computed.
module smith_predictor_delay_compensator_unit
  import spdc_pkg::*;
#(
  parameter int MAX_DELAY      = 16,
  parameter int MAX_COMPONENTS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] error_value,
  input  logic [IDX_W-1:0]         component_index,
  input  logic                     last_component,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] reference_value,
  output logic [IDX_W-1:0]         out_component_index,
  output logic                     out_last_component
);

  localparam logic [DLY_REG_W-1:0] DELAY_RESET  = 5'd1;
  localparam logic [DATA_W-1:0]    GAIN_RESET   = 32'h0001_0000;
  localparam logic [DATA_W-1:0]    PERIOD_RESET = 32'd66;

  logic [DLY_REG_W-1:0] delay_steps;
  logic [DATA_W-1:0]    loop_gain;
  logic [DATA_W-1:0]    sample_period;
  logic                 clear_req;
  logic                 hold;
  logic                 q_valid;
  item_t                q_item;
  logic                 q_pop;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign clear_req = cfg_write && (cfg_index == REG_DELAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_steps   <= DELAY_RESET;
      loop_gain     <= GAIN_RESET;
      sample_period <= PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELAY:  delay_steps   <= cfg_data[DLY_REG_W-1:0];
        REG_GAIN:   loop_gain     <= cfg_data;
        REG_PERIOD: sample_period <= cfg_data;
        default: ;
      endcase
    end
  end

  spdc_front #(
    .MAX_COMPONENTS(MAX_COMPONENTS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .error_value    (error_value),
    .component_index(component_index),
    .last_component (last_component),
    .hold           (hold),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  spdc_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  spdc_back #(
    .MAX_DELAY     (MAX_DELAY),
    .MAX_COMPONENTS(MAX_COMPONENTS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .delay_steps        (delay_steps),
    .loop_gain          (loop_gain),
    .sample_period      (sample_period),
    .clear_req          (clear_req),
    .hold               (hold),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .div_req            (div_req),
    .div_rsp            (div_rsp),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .reference_value    (reference_value),
    .out_component_index(out_component_index),
    .out_last_component (out_last_component)
  );

endmodule

/* rtl/core/spdc_checker.sv */
module spdc_checker
  import spdc_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     cfg_write,
  input logic [CFG_IDX_W-1:0]     cfg_index,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] reference_value,
  input logic [IDX_W-1:0]         out_component_index,
  input logic                     out_last_component
);

  // requests accepted but not yet delivered
  logic [3:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 4'd0;
    end else begin
      pending <= pending + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reference_value) &&
      $stable(out_component_index) && $stable(out_last_component))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 4'd0)
    else $error("result without an open request");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'd4)
    else $error("more requests in flight than the design can hold");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_write && cfg_index == REG_DELAY |=> !in_ready)
    else $error("request taken during history clear");

endmodule

bind smith_predictor_delay_compensator_unit spdc_checker u_checker (.*);

/* test/tb_top.sv */
module tb_top;
  import spdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DELAY      = 16;
  localparam int MAX_COMPONENTS = 8;
  localparam int SLOTS          = MAX_DELAY * MAX_COMPONENTS;
  localparam int CYCLE_LIMIT    = 400_000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 100;
  localparam int REPORT_CAP     = 100;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // not decoded by the block

  typedef logic signed [127:0] wide_t;
  localparam wide_t WORD_MAX = 64'hFFFF_FFFF;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         idx;
    logic                     last;
  } reference_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] e;
    logic [IDX_W-1:0]         idx;
    logic                     last;
    logic                     known;
    logic signed [DATA_W-1:0] want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 19;
  localparam int SAT_FIRST_ROW = 11;

  // rows from SAT_FIRST_ROW on run with maximum gain and zero period, so den is 1.0
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32'sh0000_0000, 3'd0, 1'b0, 1'b1, 32'sh0000_0000},
    '{SAT_MAX,        3'd1, 1'b0, 1'b0, 32'sh0},
    '{SAT_MIN,        3'd2, 1'b0, 1'b0, 32'sh0},
    '{32'sh0001_0000, 3'd3, 1'b0, 1'b0, 32'sh0},
    '{32'shFFFF_0000, 3'd4, 1'b0, 1'b0, 32'sh0},
    '{32'sh5555_AAAA, 3'd5, 1'b0, 1'b0, 32'sh0},
    '{32'shAAAA_5555, 3'd6, 1'b0, 1'b0, 32'sh0},
    '{32'sh0000_0001, 3'd7, 1'b1, 1'b0, 32'sh0},
    '{32'shFFFF_FFFF, 3'd0, 1'b1, 1'b0, 32'sh0},
    '{32'sh1234_5678, 3'd7, 1'b1, 1'b0, 32'sh0},
    '{SAT_MIN,        3'd2, 1'b1, 1'b0, 32'sh0},
    '{32'sh0000_0000, 3'd0, 1'b0, 1'b1, 32'sh0000_0000},
    '{SAT_MIN,        3'd1, 1'b0, 1'b1, SAT_MAX},
    '{SAT_MAX,        3'd2, 1'b0, 1'b1, SAT_MIN},
    '{32'sh0000_0001, 3'd3, 1'b0, 1'b0, 32'sh0},
    '{32'sh8000_0001, 3'd4, 1'b0, 1'b0, 32'sh0},
    '{32'sh0000_FFFF, 3'd5, 1'b0, 1'b0, 32'sh0},
    '{32'sh0000_0000, 3'd0, 1'b1, 1'b0, 32'sh0},
    '{SAT_MIN,        3'd1, 1'b1, 1'b0, 32'sh0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] error_value = '0;
  logic [IDX_W-1:0] component_index = '0;
  logic last_component = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] reference_value;
  logic [IDX_W-1:0] out_component_index;
  logic out_last_component;

  // predictor copy of the block's registers and history
  logic [DLY_REG_W-1:0] delay_reg = 5'd1;
  logic [DATA_W-1:0] gain_reg = 32'h0001_0000;
  logic [DATA_W-1:0] period_reg = 32'd66;
  logic signed [DATA_W-1:0] neg_hist [SLOTS];
  logic signed [DATA_W-1:0] out_hist [SLOTS];
  int unsigned ring_pos = 0;
  bit hist_valid = 1'b0;

  reference_t pending_refs [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;

  smith_predictor_delay_compensator_unit #(
    .MAX_DELAY      (MAX_DELAY),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) DUT (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .error_value         (error_value),
    .component_index     (component_index),
    .last_component      (last_component),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .reference_value     (reference_value),
    .out_component_index (out_component_index),
    .out_last_component  (out_last_component)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [DATA_W-1:0] clamp32(input wide_t v);
    wide_t hi, lo;
    hi = SAT_MAX;
    lo = SAT_MIN;
    if (v > hi) return SAT_MAX;
    if (v < lo) return SAT_MIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] predict_reference(
    input logic signed [DATA_W-1:0] e,
    input logic [IDX_W-1:0] idx,
    input logic last
  );
    int unsigned d, pos, prv, cur, old;
    wide_t neg_e, nprev, oprev, od, g, per, gt, diff, t1, t3, num, den, mag, q;
    logic signed [DATA_W-1:0] result;
    if (!hist_valid) begin
      foreach (neg_hist[k]) begin
        neg_hist[k] = '0;
        out_hist[k] = '0;
      end
      ring_pos = 0;
      hist_valid = 1'b1;
    end
    if (delay_reg == 0) d = 1;
    else if (delay_reg > MAX_DELAY) d = MAX_DELAY;
    else d = delay_reg;
    pos = ring_pos % d;
    prv = (pos + d - 1) % d;
    cur = pos * MAX_COMPONENTS + idx % MAX_COMPONENTS;
    old = prv * MAX_COMPONENTS + idx % MAX_COMPONENTS;

    neg_e = e;
    neg_e = -neg_e;
    nprev = neg_hist[old];
    oprev = out_hist[old];
    od = out_hist[cur];
    g = gain_reg;
    per = period_reg;

    gt = (g * per) >>> FRAC_W;
    if (gt > WORD_MAX) gt = WORD_MAX;
    diff = neg_e - nprev;
    // arithmetic shift gives the floor for negative products
    t1 = (diff * g) >>> FRAC_W;
    t3 = (od * gt) >>> FRAC_W;
    num = t1 + oprev + t3;
    den = 65536;
    den = den + gt;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FRAC_W) / den;
    result = clamp32((num < 0) ? -q : q);

    neg_hist[cur] = clamp32(neg_e);
    out_hist[cur] = result;
    if (last) ring_pos = (pos + 1) % d;
    return result;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_error();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(3))
        0: return SAT_MIN;
        1: return SAT_MAX;
        2: return 32'sh0;
        default: return -32'sh1;
      endcase
    end
    if (sel < 50) return int'($urandom_range(8 * 65536)) - 4 * 65536;
    return $urandom;
  endfunction

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP)
      $display("%0t: %s expected %h actual %h", $time, what, exp_v, act_v);
  endtask

  task automatic send_request(input logic signed [DATA_W-1:0] e, input logic [IDX_W-1:0] idx,
                              input logic last, input logic known,
                              input logic signed [DATA_W-1:0] want);
    int gap;
    reference_t r;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    error_value <= e;
    component_index <= idx;
    last_component <= last;
    do @(posedge clk); while (!in_ready);
    r.value = predict_reference(e, idx, last);
    if (known) r.value = want;
    r.idx = idx;
    r.last = last;
    pending_refs.push_back(r);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_refs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    if (index == REG_DELAY) begin
      delay_reg = data[DLY_REG_W-1:0];
      hist_valid = 1'b0;
    end else if (index == REG_GAIN) begin
      gain_reg = data;
    end else if (index == REG_PERIOD) begin
      period_reg = data;
    end
  endtask

  task automatic configure_phase(input logic [DATA_W-1:0] dly_word,
                                 input logic [DATA_W-1:0] gain,
                                 input logic [DATA_W-1:0] period);
    write_reg(REG_DELAY, dly_word);
    write_reg(REG_GAIN, gain);
    write_reg(REG_PERIOD, period);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // mostly whole control steps in component order, some stray requests
  task automatic run_steps(input int n_items, input int hold_at, input int pause_at);
    int sent, ncomp;
    bit held, paused;
    sent = 0;
    held = 1'b0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (hold_at >= 0 && sent >= hold_at && !held) begin
        hold_asked++;
        held = 1'b1;
      end
      if (pause_at >= 0 && sent >= pause_at && !paused) begin
        wait_for_results();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 15) begin
        send_request(pick_error(), IDX_W'($urandom_range(7)), 1'($urandom_range(1)), 1'b0, '0);
        sent++;
      end else begin
        ncomp = $urandom_range(MAX_COMPONENTS, 1);
        for (int c = 0; c < ncomp; c++)
          send_request(pick_error(), IDX_W'(c), c == ncomp - 1, 1'b0, '0);
        sent += ncomp;
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_refs.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    reference_t r;
    if (!rst && out_valid && out_ready) begin
      if (pending_refs.size() == 0) begin
        note_mismatch("unexpected reference_value", '0, reference_value);
      end else begin
        r = pending_refs.pop_front();
        if (reference_value !== r.value)
          note_mismatch("reference_value", r.value, reference_value);
        if (out_component_index !== r.idx)
          note_mismatch("out_component_index", 32'(r.idx), 32'(out_component_index));
        if (out_last_component !== r.last)
          note_mismatch("out_last_component", 32'(r.last), 32'(out_last_component));
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] dly_word, gain, period;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (r == SAT_FIRST_ROW) begin
        wait_for_results();
        configure_phase(MAX_DELAY, 32'hFFFF_FFFF, 32'h0);
      end
      send_request(directed_rows[r].e, directed_rows[r].idx, directed_rows[r].last,
                   directed_rows[r].known, directed_rows[r].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_for_results();
      case (ph)
        0: begin
          dly_word = 1; gain = 32'h0001_0000; period = 66;
        end
        1: begin
          dly_word = 4; gain = $urandom_range(32'h4_0000, 32'h4000);
          period = $urandom_range(32'h2000);
        end
        2: begin
          dly_word = MAX_DELAY; gain = 32'hFFFF_FFFF; period = 32'hFFFF_FFFF;
        end
        3: begin
          // zero delay behaves as one step
          dly_word = 0; gain = 0; period = $urandom;
        end
        4: begin
          // upper data bits are dropped, 31 clamps to the maximum depth
          dly_word = $urandom | 32'h1F; gain = $urandom_range(32'h2_0000);
          period = $urandom_range(32'h1_0000);
        end
        5: begin
          write_reg(REG_SPARE, $urandom);
          dly_word = $urandom_range(MAX_DELAY - 1, 2); gain = $urandom; period = $urandom;
        end
        6: begin
          dly_word = MAX_DELAY + 1; gain = $urandom_range(32'h3_0000, 32'h100); period = 0;
        end
        default: begin
          dly_word = $urandom_range(MAX_DELAY, 1); gain = $urandom_range(32'h2_0000);
          period = $urandom_range(32'h4000);
        end
      endcase
      configure_phase(dly_word, gain, period);
      case (ph % 4)
        0: begin
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 63; recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0; recv_stall_pct = 63;
        end
        default: begin
          send_idle_pct = 13; recv_stall_pct = 13;
        end
      endcase
      run_steps(PHASE_ITEMS, (ph == 4) ? 20 : -1, (ph == 3) ? 50 : -1);
    end

    in_valid <= 1'b0;
    while (pending_refs.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (pending_refs.size() != 0)
      note_mismatch("results never delivered", '0, 32'(pending_refs.size()));
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/spdc_pkg.sv
rtl/core/spdc_front.sv
rtl/core/spdc_div.sv
rtl/core/spdc_back.sv
rtl/core/smith_predictor_delay_compensator_unit.sv
rtl/core/spdc_checker.sv
test/tb_top.sv
